>>> hdl/lrupr_pkg.sv
// Package for the LRU page replacement block: sizes, payload structs and the
// command and status structs between controller and datapath.
// No dependencies.
package lrupr_pkg;

	localparam int MAX_FRAMES     = 8;
	localparam int PAGE_BITS      = 16;
	localparam int COUNT_BITS     = 32;
	localparam int FRAME_BITS     = 3;
	localparam int FRAME_CNT_BITS = 4;

	// One page reference.
	typedef struct packed {
		logic [PAGE_BITS-1:0] page_number;
		logic                 last_access;
	} req_t;

	// One reference result.
	typedef struct packed {
		logic                  hit;
		logic [FRAME_BITS-1:0] frame_index;
		logic                  evicted_valid;
		logic [PAGE_BITS-1:0]  evicted_page;
		logic [COUNT_BITS-1:0] fault_total;
		logic [COUNT_BITS-1:0] hit_total;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic update;
		logic cfg_write;
	} lrupr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} lrupr_sts_t;

endpackage

>>> hdl/lrupr_ctrl.sv
// Controller for the LRU page replacement block: accepts a request, then
// orders the frame update once the result register is free.
// Depends on lrupr_pkg.
module lrupr_ctrl import lrupr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  lrupr_sts_t sts,
	output lrupr_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	logic state_q;

	// The configuration register can always be written.
	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);

	// Commands follow the state and the handshakes.
	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && req_valid;
		cmd.update    = (state_q == ST_UPD) && sts.out_free;
		cmd.cfg_write = cfg_valid && cfg_ready;
	end

	// State register: a request is held until its update has gone through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/lrupr_dp.sv
// Datapath for the LRU page replacement block: frame tags, valid bits,
// recency ranks, totals, the request register and the result register.
// Depends on lrupr_pkg.
module lrupr_dp import lrupr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lrupr_cmd_t                cmd,
	output lrupr_sts_t                sts,
	input  req_t                      req_data,
	input  logic [FRAME_CNT_BITS-1:0] cfg_data,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rsp_t                      rsp_data
);

	req_t                      req_q;
	rsp_t                      rsp_q;
	logic                      rsp_valid_q;
	logic [FRAME_CNT_BITS-1:0] frames_in_use_q;
	logic [PAGE_BITS-1:0]      page_q  [MAX_FRAMES];
	logic [MAX_FRAMES-1:0]     valid_q;
	logic [FRAME_BITS-1:0]     rank_q  [MAX_FRAMES];
	logic [COUNT_BITS-1:0]     fault_q;
	logic [COUNT_BITS-1:0]     hit_q;

	logic [FRAME_CNT_BITS-1:0] n_act;
	logic [MAX_FRAMES-1:0]     active;
	logic [MAX_FRAMES-1:0]     match;
	logic [MAX_FRAMES-1:0]     empty;
	logic [FRAME_BITS-1:0]     hit_idx;
	logic [FRAME_BITS-1:0]     empty_idx;
	logic [FRAME_BITS-1:0]     lru_idx;
	logic [FRAME_BITS-1:0]     sel_idx;
	logic                      is_hit;
	logic                      any_empty;
	logic                      do_evict;
	logic [FRAME_BITS-1:0]     sel_rank;
	logic [FRAME_BITS-1:0]     rank_next [MAX_FRAMES];
	logic [COUNT_BITS-1:0]     fault_next;
	logic [COUNT_BITS-1:0]     hit_next;

	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

	// Active frame count, with zero taken as one and overlarge values clamped.
	always_comb begin
		n_act = frames_in_use_q;
		if (frames_in_use_q == '0) begin
			n_act = FRAME_CNT_BITS'(1);
		end else if (frames_in_use_q > FRAME_CNT_BITS'(MAX_FRAMES)) begin
			n_act = FRAME_CNT_BITS'(MAX_FRAMES);
		end
	end

	// Tag match and empty search over the active frames; the lowest index wins.
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			active[i] = (FRAME_CNT_BITS'(i) < n_act);
			match[i]  = active[i] && valid_q[i] && (page_q[i] == req_q.page_number);
			empty[i]  = active[i] && !valid_q[i];
			if (match[i]) begin
				hit_idx = FRAME_BITS'(i);
			end
			if (empty[i]) begin
				empty_idx = FRAME_BITS'(i);
			end
		end
		is_hit    = |match;
		any_empty = |empty;
	end

	// Least recently used active frame: the one with the largest rank.
	always_comb begin
		lru_idx = '0;
		for (int i = 1; i < MAX_FRAMES; i++) begin
			if (active[i] && (rank_q[i] > rank_q[lru_idx])) begin
				lru_idx = FRAME_BITS'(i);
			end
		end
	end

	// Frame choice, rank update and saturating totals.
	always_comb begin
		do_evict = !is_hit && !any_empty;
		if (is_hit) begin
			sel_idx = hit_idx;
		end else if (any_empty) begin
			sel_idx = empty_idx;
		end else begin
			sel_idx = lru_idx;
		end
		sel_rank = rank_q[sel_idx];
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (FRAME_BITS'(i) == sel_idx) begin
				rank_next[i] = '0;
			end else if (rank_q[i] < sel_rank) begin
				rank_next[i] = rank_q[i] + 1'b1;
			end else begin
				rank_next[i] = rank_q[i];
			end
		end
		fault_next = fault_q;
		hit_next   = hit_q;
		if (is_hit) begin
			if (hit_q != '1) begin
				hit_next = hit_q + 1'b1;
			end
		end else if (fault_q != '1) begin
			fault_next = fault_q + 1'b1;
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_data;
		end
		if (cmd.update) begin
			rsp_q.hit           <= is_hit;
			rsp_q.frame_index   <= sel_idx;
			rsp_q.evicted_valid <= do_evict;
			rsp_q.evicted_page  <= do_evict ? page_q[sel_idx] : '0;
			rsp_q.fault_total   <= fault_next;
			rsp_q.hit_total     <= hit_next;
		end
	end

	// Frame tags are only read behind a set valid bit.
	always_ff @(posedge clk) begin
		if (cmd.update && !is_hit) begin
			page_q[sel_idx] <= req_q.page_number;
		end
	end

	// Frame state, totals and configuration; a last reference clears the set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q     <= 1'b0;
			frames_in_use_q <= FRAME_CNT_BITS'(MAX_FRAMES);
			valid_q         <= '0;
			fault_q         <= '0;
			hit_q           <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_q[i] <= FRAME_BITS'(i);
			end
		end else begin
			if (cmd.update) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.cfg_write) begin
				frames_in_use_q <= cfg_data;
			end
			if (cmd.update) begin
				if (req_q.last_access) begin
					valid_q <= '0;
					fault_q <= '0;
					hit_q   <= '0;
					for (int i = 0; i < MAX_FRAMES; i++) begin
						rank_q[i] <= FRAME_BITS'(i);
					end
				end else begin
					valid_q[sel_idx] <= 1'b1;
					fault_q          <= fault_next;
					hit_q            <= hit_next;
					rank_q           <= rank_next;
				end
			end
		end
	end

endmodule

>>> hdl/lru_page_replacement.sv
// LRU page replacement top level. A taken request is held in the request
// register, and its result is registered in the controller's update step;
// no request is taken until that step. A stalled result holds back the update
// of the next request, and the request channel stalls until the result is taken.
// Reset: all frames empty, ranks equal to frame index, totals zero,
// frames_in_use set to the built frame count.
module lru_page_replacement import lrupr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  req_t                      req_data,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rsp_t                      rsp_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [FRAME_CNT_BITS-1:0] cfg_data
);

	lrupr_cmd_t cmd;
	lrupr_sts_t sts;

	// Sequencing of requests and updates.
	lrupr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Frame set, totals and result register.
	lrupr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req_data),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

>>> hdl/lrupr_checker.sv
// Port-level checks for the LRU page replacement block, bound to the top level.
// Depends on lrupr_pkg.
module lrupr_checker import lrupr_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input req_t                      req_data,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input rsp_t                      rsp_data,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [FRAME_CNT_BITS-1:0] cfg_data
);

	// A stalled result stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

	// A hit never displaces a page.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.hit |-> !rsp_data.evicted_valid)
		else $error("eviction reported on a hit");

	// Without an eviction the evicted page reads as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.evicted_valid |-> rsp_data.evicted_page == '0)
		else $error("evicted page not zero");

	// In the cycle after a request is taken, the request channel stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken back to back");

endmodule

bind lru_page_replacement lrupr_checker u_chk (.*);
